/* rtl/sorted_table_search_macros.svh */
// ----------------------------------------------------------------------------
// sorted_table_search assertion macros
// concurrent assertion shorthands shared by the table search rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_SEARCH_MACROS_SVH
`define SORTED_TABLE_SEARCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define STS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// shared types and constants of the sorted table search block
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

   // default table depth
   localparam int DefaultDepth = 256;

   // data and result widths
   localparam int DataW = 32;
   localparam int PosW  = 8;

   // request actions
   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_ACCEPTED  = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SORT_LD0,
      S_SORT_HEAD,
      S_SORT_RD,
      S_SORT_CMP,
      S_SORT_TAIL,
      S_SRCH_ADDR,
      S_SRCH_CMP
   } state_type;

   // compare unit result
   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_res_type;

endpackage

`default_nettype wire

/* rtl/sts_ram.sv */
// ----------------------------------------------------------------------------
// sts_ram
// table storage: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sts_ram
   import sts_pkg::*;
#(
   parameter int DEPTH = DefaultDepth,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [DataW-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [DataW-1:0] rd_data
);

   logic [DataW-1:0] mem_ff [DEPTH];
   logic [DataW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/sts_cmp.sv */
// ----------------------------------------------------------------------------
// sts_cmp
// shared signed compare unit used by both the sort and the search
// ----------------------------------------------------------------------------
`default_nettype none

module sts_cmp
   import sts_pkg::*;
(
   input  wire logic signed [DataW-1:0] op_a,
   input  wire logic signed [DataW-1:0] op_b,
   output cmp_res_type                  res
);

   // signed order and equality
   always_comb begin
      res.gt = op_a > op_b;
      res.eq = op_a == op_b;
   end

endmodule

`default_nettype wire

/* rtl/sorted_table_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_search
// table of signed values with append, clear and sort-on-demand binary search
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; every request
// gives exactly one response beat, shown on rsp_* with rsp_valid for one
// cycle, and the receiver cannot stall it. Append, clear and the unused
// action code keep busy low, and the response follows on the next cycle.
// A search on an empty table answers the same way. Otherwise a search
// raises busy and first, if anything was appended since the last sort,
// bubble-sorts the table in place: passes over the n stored values repeat
// until one makes no swap (at most n passes). The binary search then makes
// at most log2(n) + 1 probes, each a read of the table and a compare. The
// pace is set by the single read port of the table memory and the one shared
// compare unit. The table needs no clearing after reset: only slots below
// the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_table_search_macros.svh"

module sorted_table_search
   import sts_pkg::*;
#(
   parameter int DEPTH = DefaultDepth
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [1:0]              req_action,
   input  wire logic signed [DataW-1:0] req_value,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [PosW-1:0]              rsp_position
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // sequencer and working registers
   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    sorted_ff, sorted_in;
   logic [AW-1:0]           j_ff, j_in;
   logic [DataW-1:0]        cur_ff, cur_in;
   logic                    swap_ff, swap_in;
   logic [CW-1:0]           head_ff, head_in;
   logic [CW-1:0]           hi_ff, hi_in;
   logic [AW-1:0]           mid_ff, mid_in;
   logic [DataW-1:0]        key_ff, key_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [PosW-1:0]         rsp_position_ff, rsp_position_in;

   // memory and compare unit hookup
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [DataW-1:0]        wr_data;
   logic [AW-1:0]           rd_addr;
   logic [DataW-1:0]        rd_data;
   logic signed [DataW-1:0] op_a;
   logic signed [DataW-1:0] op_b;
   cmp_res_type             cmp_res;

   logic [CW:0]             mid_sum;
   logic [CW:0]             j_plus2;

   sts_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sts_cmp u_cmp (
      .op_a (op_a),
      .op_b (op_b),
      .res  (cmp_res)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sorted_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      j_ff            <= j_in;
      cur_ff          <= cur_in;
      swap_ff         <= swap_in;
      head_ff         <= head_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      key_ff          <= key_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
   end

   // probe midpoint and pass end check
   always_comb begin
      mid_sum = (CW+1)'(head_ff) + (CW+1)'(hi_ff) - (CW+1)'(1);
      j_plus2 = (CW+1)'(j_ff) + (CW+1)'(2);
   end

   // next state and outputs
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      sorted_in       = sorted_ff;
      j_in            = j_ff;
      cur_in          = cur_ff;
      swap_in         = swap_ff;
      head_in         = head_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      key_in          = key_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      wr_en           = 1'b0;
      wr_addr         = j_ff;
      wr_data         = cur_ff;
      rd_addr         = j_ff;
      op_a            = cur_ff;
      op_b            = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_position_in = '0;
               rsp_status_in   = ST_ACCEPTED;
               case (req_action)
                  ACT_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = count_ff[AW-1:0];
                        wr_data   = req_value;
                        count_in  = count_ff + CW'(1);
                        sorted_in = 1'b0;
                     end
                  end
                  ACT_SEARCH: begin
                     key_in  = req_value;
                     head_in = '0;
                     hi_in   = count_ff;
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                     end else if (!sorted_ff) begin
                        state_in = S_SORT_LD0;
                     end else begin
                        state_in = S_SRCH_ADDR;
                     end
                  end
                  ACT_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                     sorted_in    = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // start a bubble pass: fetch the first entry
         S_SORT_LD0: begin
            rd_addr  = '0;
            j_in     = '0;
            swap_in  = 1'b0;
            state_in = S_SORT_HEAD;
         end

         // first entry becomes the carried value
         S_SORT_HEAD: begin
            cur_in = rd_data;
            if (count_ff == CW'(1)) begin
               sorted_in = 1'b1;
               state_in  = S_SRCH_ADDR;
            end else begin
               state_in = S_SORT_RD;
            end
         end

         // fetch the neighbor of the carried value
         S_SORT_RD: begin
            rd_addr  = j_ff + AW'(1);
            state_in = S_SORT_CMP;
         end

         // keep the larger one carried, drop the smaller into slot j
         S_SORT_CMP: begin
            op_a  = cur_ff;
            op_b  = rd_data;
            wr_en = 1'b1;
            if (cmp_res.gt) begin
               wr_data = rd_data;
               swap_in = 1'b1;
            end else begin
               wr_data = cur_ff;
               cur_in  = rd_data;
            end
            j_in = j_ff + AW'(1);
            if (j_plus2 == (CW+1)'(count_ff)) begin
               state_in = S_SORT_TAIL;
            end else begin
               state_in = S_SORT_RD;
            end
         end

         // carried value lands in the last slot
         S_SORT_TAIL: begin
            wr_en   = 1'b1;
            wr_data = cur_ff;
            if (swap_ff) begin
               state_in = S_SORT_LD0;
            end else begin
               sorted_in = 1'b1;
               state_in  = S_SRCH_ADDR;
            end
         end

         // issue the next probe or give up
         S_SRCH_ADDR: begin
            if (head_ff < hi_ff) begin
               mid_in   = AW'(mid_sum >> 1);
               rd_addr  = AW'(mid_sum >> 1);
               state_in = S_SRCH_CMP;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_NOT_FOUND;
               rsp_position_in = '0;
               state_in        = S_IDLE;
            end
         end

         // compare probe against key and narrow the range
         S_SRCH_CMP: begin
            op_a = rd_data;
            op_b = key_ff;
            if (cmp_res.eq) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_FOUND;
               rsp_position_in = PosW'(mid_ff);
               state_in        = S_IDLE;
            end else begin
               if (cmp_res.gt) begin
                  hi_in = CW'(mid_ff);
               end else begin
                  head_in = CW'(mid_ff) + CW'(1);
               end
               state_in = S_SRCH_ADDR;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy         = state_ff != S_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;

   // checks
   `STS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH),
      "fill count beyond table depth")
   `STS_ASSERT_NOW(a_pos_zero, clock, reset,
      rsp_valid && rsp_status != ST_FOUND, rsp_position == '0,
      "nonzero position on a miss")
   `STS_ASSERT_NEXT(a_empty_search, clock, reset,
      start && !busy && req_action == ACT_SEARCH && count_ff == '0,
      rsp_valid && rsp_status == ST_NOT_FOUND,
      "empty table search did not answer not found")
   `STS_ASSERT_NOW(a_sort_unsorted, clock, reset,
      state_ff == S_SORT_RD || state_ff == S_SORT_CMP, !sorted_ff,
      "sort running on a table marked sorted")

endmodule

`default_nettype wire
